[src/pnns_pkg.sv]
package pnns_pkg;

    // Field widths of the stream items and configuration registers.
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 18;
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 32;
    localparam int COORD_W = 11;
    localparam int SDIM_W  = 10;
    localparam int DDIM_W  = 12;
    localparam int CCNT_W  = 9;

    // Scaled coordinate arithmetic: product, quotient and source address.
    localparam int PROD_W     = COORD_W + SDIM_W;
    localparam int QUO_W      = SDIM_W;
    localparam int SADDR_W    = 22;
    localparam int DIV_STAGES = QUO_W + 1;

    // Item kinds carried in tuser.
    localparam logic [MODE_W-1:0] MODE_LOAD_SRC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_PAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REQUEST  = 2'd2;

    // Register indexes on the configuration port.
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_COUNT = 3'd4;

    typedef struct packed {
        logic [SDIM_W-1:0] src_width;
        logic [SDIM_W-1:0] src_height;
        logic [DDIM_W-1:0] dst_width;
        logic [DDIM_W-1:0] dst_height;
        logic [CCNT_W-1:0] color_count;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ADDR_W-1:0]  load_address;
        logic [IDX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] palette_color;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
    } item_t;

    typedef struct packed {
        item_t             item;
        logic              in_range;
        logic [PROD_W-1:0] rem_x;
        logic [PROD_W-1:0] rem_y;
        logic [QUO_W-1:0]  q_x;
        logic [QUO_W-1:0]  q_y;
    } div_stage_t;

    typedef struct packed {
        item_t            item;
        logic             in_range;
        logic [QUO_W-1:0] row;
        logic [QUO_W-1:0] col;
    } coord_item_t;

endpackage

[src/palette_nearest_neighbor_scaler.sv]
// Pipeline: a request accepted on the slave side passes through one multiply stage,
// ten divide stages, and the address, source store and palette stages before its result
// shows on the master side. Throughput is one item per cycle while m_tready holds, set
// by the one bit per stage division pipeline.
// Reset (rst_n, asynchronous, active low) empties the pipeline and returns the
// registers to their reset values; both stores hold undefined data until loaded.
module palette_nearest_neighbor_scaler #(
    parameter int MAX_SRC_PIXELS = 262144,
    parameter int PALETTE_DEPTH  = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration port, register i at byte address 4*i.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // load_address[17:0], pixel_index[25:18], palette_color[57:26],
    // dest_x[68:58], dest_y[79:69]
    input  logic [79:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_color[31:0], out_x[42:32], out_y[53:43], zero fill [55:54]
    output logic [55:0] m_tdata,
    // write_enable[0]
    output logic [0:0]  m_tuser
);
    import pnns_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_index;

    item_t                in_item;
    coord_item_t          scaled_item;
    logic                 scaled_valid;
    logic                 scaled_ready;

    logic [COLOR_W-1:0]   pixel_color;
    logic                 write_enable;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;

    // The configuration port never waits, so a write completes in its access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:2];

    // Each register keeps only its own width of the written word. Writes beyond
    // the register list are accepted and dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index)
                REG_SRC_WIDTH:   cfg_next.src_width   = pwdata[SDIM_W-1:0];
                REG_SRC_HEIGHT:  cfg_next.src_height  = pwdata[SDIM_W-1:0];
                REG_DST_WIDTH:   cfg_next.dst_width   = pwdata[DDIM_W-1:0];
                REG_DST_HEIGHT:  cfg_next.dst_height  = pwdata[DDIM_W-1:0];
                REG_COLOR_COUNT: cfg_next.color_count = pwdata[CCNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width   <= SDIM_W'(1);
            cfg_reg.src_height  <= SDIM_W'(1);
            cfg_reg.dst_width   <= DDIM_W'(1);
            cfg_reg.dst_height  <= DDIM_W'(1);
            cfg_reg.color_count <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Reads return the register value, zero extended to the bus width.
    always_comb
    begin
        case (reg_index)
            REG_SRC_WIDTH:   prdata = 32'(cfg_reg.src_width);
            REG_SRC_HEIGHT:  prdata = 32'(cfg_reg.src_height);
            REG_DST_WIDTH:   prdata = 32'(cfg_reg.dst_width);
            REG_DST_HEIGHT:  prdata = 32'(cfg_reg.dst_height);
            REG_COLOR_COUNT: prdata = 32'(cfg_reg.color_count);
            default:         prdata = '0;
        endcase
    end

    // Unpack the input transfer. Every item kind travels the whole pipeline so
    // that loads reach each store in order with the requests around them.
    always_comb
    begin
        in_item.mode          = s_tuser;
        in_item.load_address  = s_tdata[17:0];
        in_item.pixel_index   = s_tdata[25:18];
        in_item.palette_color = s_tdata[57:26];
        in_item.dest_x        = s_tdata[68:58];
        in_item.dest_y        = s_tdata[79:69];
    end

    // Source row and column: one multiply, then a ten stage restoring divider
    // for each coordinate.
    pnns_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .out_valid (scaled_valid),
        .out_ready (scaled_ready),
        .out_item  (scaled_item)
    );

    // Source address, source store and palette. Only requests leave the last
    // stage, so load transfers produce no result.
    pnns_lookup #(
        .MAX_SRC_PIXELS (MAX_SRC_PIXELS),
        .PALETTE_DEPTH  (PALETTE_DEPTH)
    ) u_lookup (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (scaled_valid),
        .in_ready     (scaled_ready),
        .in_item      (scaled_item),
        .cfg          (cfg_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .pixel_color  (pixel_color),
        .write_enable (write_enable),
        .out_x        (out_x),
        .out_y        (out_y)
    );

    assign m_tdata = {2'b00, out_y, out_x, pixel_color};
    assign m_tuser = write_enable;

endmodule

[src/pnns_scale.sv]
module pnns_scale (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pnns_pkg::item_t       in_item,
    input  pnns_pkg::cfg_t        cfg,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pnns_pkg::coord_item_t out_item
);
    import pnns_pkg::*;

    localparam int NS = DIV_STAGES;

    div_stage_t  stage_reg  [NS];
    div_stage_t  stage_next [NS];
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_in;
    logic [NS:0]   en;

    // A stage loads when it is empty or its content moves on.
    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign valid_in = {valid_reg[NS-2:0], in_valid};

    // First stage: both products and the destination range check.
    always_comb
    begin
        stage_next[0].item     = in_item;
        stage_next[0].in_range = (DDIM_W'(in_item.dest_x) < cfg.dst_width) &&
                                 (DDIM_W'(in_item.dest_y) < cfg.dst_height);
        stage_next[0].rem_x    = PROD_W'(in_item.dest_x) * PROD_W'(cfg.src_width);
        stage_next[0].rem_y    = PROD_W'(in_item.dest_y) * PROD_W'(cfg.src_height);
        stage_next[0].q_x      = '0;
        stage_next[0].q_y      = '0;
    end

    // One restoring division step per stage, most significant quotient bit first.
    for (genvar k = 1; k < NS; k++)
    begin : g_div
        localparam int SH = QUO_W - k;
        logic [PROD_W-1:0] trial_x;
        logic [PROD_W-1:0] trial_y;

        always_comb
        begin
            trial_x       = PROD_W'(cfg.dst_width) << SH;
            trial_y       = PROD_W'(cfg.dst_height) << SH;
            stage_next[k] = stage_reg[k-1];
            if (stage_reg[k-1].rem_x >= trial_x)
            begin
                stage_next[k].rem_x  = stage_reg[k-1].rem_x - trial_x;
                stage_next[k].q_x[SH] = 1'b1;
            end
            if (stage_reg[k-1].rem_y >= trial_y)
            begin
                stage_next[k].rem_y  = stage_reg[k-1].rem_y - trial_y;
                stage_next[k].q_y[SH] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign in_ready          = en[0];
    assign out_valid         = valid_reg[NS-1];
    assign out_item.item     = stage_reg[NS-1].item;
    assign out_item.in_range = stage_reg[NS-1].in_range;
    assign out_item.row      = stage_reg[NS-1].q_y;
    assign out_item.col      = stage_reg[NS-1].q_x;

endmodule

[src/pnns_lookup.sv]
module pnns_lookup #(
    parameter int MAX_SRC_PIXELS = 262144,
    parameter int PALETTE_DEPTH  = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pnns_pkg::coord_item_t         in_item,
    input  pnns_pkg::cfg_t                cfg,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pnns_pkg::COLOR_W-1:0]  pixel_color,
    output logic                          write_enable,
    output logic [pnns_pkg::COORD_W-1:0]  out_x,
    output logic [pnns_pkg::COORD_W-1:0]  out_y
);
    import pnns_pkg::*;

    localparam int SRC_AW = $clog2(MAX_SRC_PIXELS);
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    // Stage A: linear source address.
    logic               a_valid_reg;
    item_t              a_item_reg;
    logic [SADDR_W-1:0] a_saddr_reg;
    logic [SADDR_W-1:0] a_saddr_next;
    logic               a_ok_reg;
    logic               a_ok_next;

    // Stage B: source store access.
    logic               b_valid_reg;
    item_t              b_item_reg;
    logic               b_ok_reg;
    logic [IDX_W-1:0]   src_q_reg;
    logic [IDX_W-1:0]   src_mem [MAX_SRC_PIXELS];
    logic               src_we;
    logic [SRC_AW-1:0]  src_wa;
    logic [SRC_AW-1:0]  src_ra;

    // Stage C: palette access, drives the result.
    logic               c_valid_reg;
    logic               c_valid_next;
    logic               c_we_reg;
    logic               c_we_next;
    logic [COORD_W-1:0] c_x_reg;
    logic [COORD_W-1:0] c_y_reg;
    logic [COLOR_W-1:0] pal_q_reg;
    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
    logic               pal_we;
    logic [PAL_AW-1:0]  pal_wa;
    logic [PAL_AW-1:0]  pal_ra;

    logic en_a;
    logic en_b;
    logic en_c;

    assign en_c     = !c_valid_reg || out_ready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    always_comb
    begin
        a_saddr_next = SADDR_W'(in_item.row) * SADDR_W'(cfg.src_width) +
                       SADDR_W'(in_item.col);
        a_ok_next    = in_item.in_range && (a_saddr_next < SADDR_W'(MAX_SRC_PIXELS));
    end

    assign src_we = a_valid_reg && (a_item_reg.mode == MODE_LOAD_SRC) &&
                    (SADDR_W'(a_item_reg.load_address) < SADDR_W'(MAX_SRC_PIXELS));
    assign src_wa = SRC_AW'(SADDR_W'(a_item_reg.load_address));
    assign src_ra = a_saddr_reg[SRC_AW-1:0];

    always_comb
    begin
        c_valid_next = b_valid_reg && (b_item_reg.mode == MODE_REQUEST);
        c_we_next    = b_ok_reg &&
                       (CCNT_W'(src_q_reg) < cfg.color_count) &&
                       (CCNT_W'(src_q_reg) < CCNT_W'(PALETTE_DEPTH));
    end

    assign pal_we = b_valid_reg && (b_item_reg.mode == MODE_LOAD_PAL) &&
                    (b_item_reg.load_address < ADDR_W'(PALETTE_DEPTH));
    assign pal_wa = b_item_reg.load_address[PAL_AW-1:0];
    assign pal_ra = src_q_reg[PAL_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c)
            begin
                c_valid_reg <= c_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_item_reg  <= in_item.item;
            a_saddr_reg <= a_saddr_next;
            a_ok_reg    <= a_ok_next;
        end
        if (en_b)
        begin
            b_item_reg <= a_item_reg;
            b_ok_reg   <= a_ok_reg;
        end
        if (en_c)
        begin
            c_we_reg <= c_we_next;
            c_x_reg  <= b_item_reg.dest_x;
            c_y_reg  <= b_item_reg.dest_y;
        end
    end

    // Loads write where requests read, so every access keeps stream order.
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            if (src_we)
            begin
                src_mem[src_wa] <= a_item_reg.pixel_index;
            end
            src_q_reg <= src_mem[src_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            if (pal_we)
            begin
                pal_mem[pal_wa] <= b_item_reg.palette_color;
            end
            pal_q_reg <= pal_mem[pal_ra];
        end
    end

    assign out_valid    = c_valid_reg;
    assign write_enable = c_we_reg;
    assign pixel_color  = c_we_reg ? pal_q_reg : '0;
    assign out_x        = c_x_reg;
    assign out_y        = c_y_reg;

endmodule
